FILE: hw/rtl/assert_macros.svh
// assertion macros for the rtl files
// no dependencies; expects clk and arst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clk edge out of reset
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on every rising clk edge out of reset
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/rmf_pkg.sv
// shared types and constants of the rolling median filter
// no dependencies
package rmf_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int NUM_AXES   = 3;
	localparam int WINDOW_DEF = 5;

	// axis slots in the packed stream words
	localparam int AXIS_X = 0;
	localparam int AXIS_Y = 1;
	localparam int AXIS_Z = 2;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [SAMPLE_W:0]   sample_sum_t;

endpackage

FILE: hw/rtl/rolling_median_filter.sv
// rolling median filter top level: per-axis sliding windows and rank-select median
// depends on rmf_pkg and assert_macros.svh
`include "assert_macros.svh"

// Three-axis sliding-window median. Each transfer on the slave stream brings one
// signed 16-bit sample for X, Y and Z; each is pushed into its own window of the
// latest WINDOW samples (oldest dropped). Every input transfer yields exactly one
// output transfer. Until WINDOW samples have arrived, tuser (window_full) is 0 and
// all medians are 0; the transfer that completes the window already carries a
// valid median. For an even WINDOW the median is the floor of the mean of the two
// middle values. The block takes one sample triple per clock while the master side
// keeps tready high; each input transfer passes through the window registers,
// a rank stage (all pairwise compares of a window in parallel, one rank count per
// entry) and the output register that selects the middle entries. The whole
// pipeline stalls only when the output register is full and not taken. No clearing
// pass after reset: the window contents are only read once the fill counter shows
// them written.
module rolling_median_filter
	import rmf_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEF // window depth, 1 to 15
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// input samples
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [3*SAMPLE_W-1:0]     s_axis_tdata,  // sample_x, sample_y, sample_z
	// medians
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [3*SAMPLE_W-1:0]     m_axis_tdata,  // median_x, median_y, median_z
	output logic                      m_axis_tuser   // window_full
);

	localparam int FILL_W = $clog2(WINDOW + 1);
	localparam int RANK_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	// ranks of the two middle entries; equal for an odd window
	localparam int RANK_LO = (WINDOW - 1) / 2;
	localparam int RANK_HI = WINDOW / 2;

	// pipeline advance: output register free or being drained
	logic pipe_en;
	logic in_xfer;

	// stage 1: window contents (newest at highest index) and fill count
	sample_t           win_q [NUM_AXES][WINDOW];
	logic [FILL_W-1:0] fill_q;
	logic              valid_s1;

	// stage 2: window copy plus rank of every entry
	sample_t           win_s2  [NUM_AXES][WINDOW];
	logic [RANK_W-1:0] rank_s2 [NUM_AXES][WINDOW];
	logic              full_s2;
	logic              valid_s2;

	// stage 3: output register
	sample_t           med_s3 [NUM_AXES];
	logic              full_s3;
	logic              valid_s3;

	logic [RANK_W-1:0] rank_d [NUM_AXES][WINDOW];
	sample_t           med_d  [NUM_AXES];

	assign pipe_en       = !valid_s3 || m_axis_tready;
	assign s_axis_tready = pipe_en;
	assign in_xfer       = s_axis_tvalid && pipe_en;

	// window shift; contents need no reset, they are read only once filled
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				for (int i = 0; i < WINDOW - 1; i++) begin
					win_q[a][i] <= win_q[a][i+1];
				end
				win_q[a][WINDOW-1] <= s_axis_tdata[a*SAMPLE_W +: SAMPLE_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			valid_s1 <= 1'b0;
		end else if (pipe_en) begin
			valid_s1 <= s_axis_tvalid;
			if (s_axis_tvalid && (fill_q != FILL_W'(WINDOW))) begin
				fill_q <= fill_q + FILL_W'(1);
			end
		end
	end

	// rank = entries strictly smaller, ties broken by position, so ranks form a permutation
	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			for (int i = 0; i < WINDOW; i++) begin
				rank_d[a][i] = '0;
				for (int j = 0; j < WINDOW; j++) begin
					if ((j != i) && ((win_q[a][j] < win_q[a][i]) ||
					    ((win_q[a][j] == win_q[a][i]) && (j < i)))) begin
						rank_d[a][i] = rank_d[a][i] + RANK_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			win_s2  <= win_q;
			rank_s2 <= rank_d;
			full_s2 <= (fill_q == FILL_W'(WINDOW));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (pipe_en) begin
			valid_s2 <= valid_s1;
		end
	end

	// pick the two middle entries and take the floor of their mean
	always_comb begin
		sample_t     lo;
		sample_t     hi;
		sample_sum_t sum;
		for (int a = 0; a < NUM_AXES; a++) begin
			lo = '0;
			hi = '0;
			for (int i = 0; i < WINDOW; i++) begin
				lo = lo | (win_s2[a][i] & {SAMPLE_W{rank_s2[a][i] == RANK_W'(RANK_LO)}});
				hi = hi | (win_s2[a][i] & {SAMPLE_W{rank_s2[a][i] == RANK_W'(RANK_HI)}});
			end
			sum       = sample_sum_t'(lo) + sample_sum_t'(hi);
			med_d[a]  = full_s2 ? sum[SAMPLE_W:1] : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			med_s3  <= med_d;
			full_s3 <= full_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (pipe_en) begin
			valid_s3 <= valid_s2;
		end
	end

	assign m_axis_tvalid = valid_s3;
	assign m_axis_tuser  = full_s3;
	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			m_axis_tdata[a*SAMPLE_W +: SAMPLE_W] = med_s3[a];
		end
	end

	// checks
	`ASSERT_SAME(a_fill_bound, 1'b1, fill_q <= FILL_W'(WINDOW),
		"fill count beyond window depth")
	`ASSERT_NEXT(a_fill_sticky, fill_q == FILL_W'(WINDOW), fill_q == FILL_W'(WINDOW),
		"fill count left saturation")
	`ASSERT_NEXT(a_accept_to_s1, s_axis_tvalid && s_axis_tready, valid_s1,
		"accepted transfer did not enter the window stage")
	`ASSERT_SAME(a_zero_until_full, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0,
		"nonzero median before window full")

endmodule
